### rtl/sps_pkg.sv
// Shared types and constants of the segment point sampler.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package sps_pkg;

  // Coordinate and arithmetic widths
  localparam int COORD_W   = 20;
  localparam int DELTA_W   = COORD_W + 1;        // end - start
  localparam int MAG_W     = COORD_W;            // |end - start|
  localparam int SQ_W      = 2 * MAG_W;          // squared magnitude
  localparam int RAD_W     = 2 * DELTA_W;        // radicand, even width
  localparam int ROOT_W    = DELTA_W;            // square root result
  localparam int STEP_W    = 16;
  localparam int DIV_W     = MAG_W + 9;          // |d| * 256 plus rounding term
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int SX_W      = DIV_W;              // signed per-point increment
  localparam int MAX_STEPS = 61;
  localparam int N_W       = $clog2(MAX_STEPS + 1);
  localparam int ACC_W     = SX_W + N_W + 1;     // i * increment
  localparam int PT_W      = ACC_W - 7;          // start + (acc >>> 8)

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(41);

  localparam logic signed [PT_W-1:0] PT_HI = PT_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam logic signed [PT_W-1:0] PT_LO = -PT_HI - PT_W'(1);

  // APB register map
  localparam int APB_AW = 3;
  localparam logic REG_STEP_SIZE = 1'b0;         // index bit paddr[2]

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_END    = 2'd1,
    KIND_SAMPLE = 2'd2
  } point_kind_e;

  typedef enum logic [1:0] {
    DIV_ROOT = 2'd0,
    DIV_DX   = 2'd1,
    DIV_DY   = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } seg_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    point_kind_e               point_kind;
    logic                      count_capped;
    logic                      last;
  } point_out_t;

  // Controller to datapath
  typedef struct packed {
    logic        load;
    logic        square;
    logic        sum;
    logic        sqrt_step;
    logic        div_start;
    logic        div_take;
    div_sel_e    div_sel;
    logic        emit;
    point_kind_e emit_kind;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sqrt_last;
    logic div_done;
    logic last_point;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/sps_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sps_pkg for operand widths.
`default_nettype none

module sps_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [sps_pkg::DIV_W-1:0]      dividend_i,
  input  wire logic [sps_pkg::STEP_W-1:0]     divisor_i,
  output logic                                done_o,
  output logic [sps_pkg::DIV_W-1:0]           quotient_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [sps_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [sps_pkg::STEP_W-1:0]       rem_q, rem_d;
  logic [sps_pkg::STEP_W-1:0]       dvs_q, dvs_d;
  logic [sps_pkg::DIV_W-1:0]        quo_q, quo_d;
  logic [sps_pkg::STEP_W:0]         rem_sh;
  logic                             fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[sps_pkg::DIV_W-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = sps_pkg::DIV_CNT_W'(sps_pkg::DIV_W - 1);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? sps_pkg::STEP_W'(rem_sh - {1'b0, dvs_q})
                   : rem_sh[sps_pkg::STEP_W-1:0];
      quo_d = {quo_q[sps_pkg::DIV_W-2:0], fits};
      cnt_d = cnt_q - sps_pkg::DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### rtl/sps_dp.sv
// Datapath: squares, iterative square root, shared divider, point stepping
// and the output register. Depends on sps_pkg and sps_div.
`default_nettype none

module sps_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [sps_pkg::STEP_W-1:0]  step_size_i,
  input  wire sps_pkg::seg_in_t            seg_i,
  input  wire sps_pkg::dp_cmd_t            cmd_i,
  output sps_pkg::dp_sts_t                 sts_o,
  output sps_pkg::point_out_t              point_o
);

  logic signed [sps_pkg::COORD_W-1:0] x1_q, y1_q, x2_q, y2_q;
  logic signed [sps_pkg::DELTA_W-1:0] dx_q, dy_q;
  logic [sps_pkg::SQ_W-1:0]           sqx_q, sqy_q;
  logic [sps_pkg::RAD_W-1:0]          rad_q, res_q, bit_q;
  logic [sps_pkg::N_W-1:0]            n_q, idx_q;
  logic                               capped_q;
  logic signed [sps_pkg::SX_W-1:0]    sx_q, sy_q;
  logic signed [sps_pkg::ACC_W-1:0]   acc_x_q, acc_y_q;
  sps_pkg::point_out_t                out_q;

  logic [sps_pkg::MAG_W-1:0]          mag_x, mag_y;
  logic [sps_pkg::RAD_W-1:0]          trial;
  logic                               div_start, div_done;
  logic [sps_pkg::DIV_W-1:0]          dividend, quotient;
  logic [sps_pkg::STEP_W-1:0]         divisor;
  logic signed [sps_pkg::SX_W-1:0]    q_signed;
  logic                               last_point;

  function automatic logic signed [sps_pkg::COORD_W-1:0] sample_coord(
    input logic signed [sps_pkg::COORD_W-1:0] base,
    input logic signed [sps_pkg::ACC_W-1:0]   acc
  );
    logic signed [sps_pkg::PT_W-1:0] pt;
    pt = sps_pkg::PT_W'(base) + sps_pkg::PT_W'(acc >>> 8);
    if (pt > sps_pkg::PT_HI) begin
      pt = sps_pkg::PT_HI;
    end else if (pt < sps_pkg::PT_LO) begin
      pt = sps_pkg::PT_LO;
    end
    return pt[sps_pkg::COORD_W-1:0];
  endfunction

  always_comb begin
    mag_x = sps_pkg::MAG_W'(dx_q[sps_pkg::DELTA_W-1] ? -dx_q : dx_q);
    mag_y = sps_pkg::MAG_W'(dy_q[sps_pkg::DELTA_W-1] ? -dy_q : dy_q);
    trial = res_q + bit_q;
    last_point = (idx_q == n_q);
  end

  // Divider operands: root / step, then |d|*256 (+ n-1 for floor on negatives) / n
  always_comb begin
    divisor  = sps_pkg::STEP_W'(n_q);
    dividend = '0;
    case (cmd_i.div_sel)
      sps_pkg::DIV_ROOT: begin
        dividend = sps_pkg::DIV_W'(res_q[sps_pkg::ROOT_W-1:0]);
        divisor  = (step_size_i == '0) ? sps_pkg::STEP_W'(1) : step_size_i;
      end
      sps_pkg::DIV_DX: begin
        dividend = sps_pkg::DIV_W'({mag_x, 8'd0})
                 + (dx_q[sps_pkg::DELTA_W-1] ? sps_pkg::DIV_W'(n_q - sps_pkg::N_W'(1))
                                              : '0);
      end
      sps_pkg::DIV_DY: begin
        dividend = sps_pkg::DIV_W'({mag_y, 8'd0})
                 + (dy_q[sps_pkg::DELTA_W-1] ? sps_pkg::DIV_W'(n_q - sps_pkg::N_W'(1))
                                              : '0);
      end
      default: begin
        dividend = '0;
      end
    endcase
  end

  assign div_start = cmd_i.div_start;
  assign q_signed  = $signed(sps_pkg::SX_W'(quotient));

  sps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x1_q <= seg_i.start_x;
      y1_q <= seg_i.start_y;
      x2_q <= seg_i.end_x;
      y2_q <= seg_i.end_y;
      dx_q <= sps_pkg::DELTA_W'(seg_i.end_x) - sps_pkg::DELTA_W'(seg_i.start_x);
      dy_q <= sps_pkg::DELTA_W'(seg_i.end_y) - sps_pkg::DELTA_W'(seg_i.start_y);
    end
    if (cmd_i.square) begin
      sqx_q <= sps_pkg::SQ_W'(mag_x) * sps_pkg::SQ_W'(mag_x);
      sqy_q <= sps_pkg::SQ_W'(mag_y) * sps_pkg::SQ_W'(mag_y);
    end
    if (cmd_i.sum) begin
      rad_q <= sps_pkg::RAD_W'(sqx_q) + sps_pkg::RAD_W'(sqy_q);
      res_q <= '0;
      bit_q <= sps_pkg::RAD_W'(1) << (sps_pkg::RAD_W - 2);
    end
    if (cmd_i.sqrt_step) begin
      if (rad_q >= trial) begin
        rad_q <= rad_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.div_take) begin
      case (cmd_i.div_sel)
        sps_pkg::DIV_ROOT: begin
          if (quotient >= sps_pkg::DIV_W'(sps_pkg::MAX_STEPS)) begin
            n_q      <= sps_pkg::N_W'(sps_pkg::MAX_STEPS);
            capped_q <= 1'b1;
          end else begin
            n_q      <= quotient[sps_pkg::N_W-1:0] + sps_pkg::N_W'(1);
            capped_q <= 1'b0;
          end
        end
        sps_pkg::DIV_DX: begin
          sx_q <= dx_q[sps_pkg::DELTA_W-1] ? -q_signed : q_signed;
        end
        sps_pkg::DIV_DY: begin
          sy_q <= dy_q[sps_pkg::DELTA_W-1] ? -q_signed : q_signed;
        end
        default: begin
          sx_q <= sx_q;
        end
      endcase
    end
    if (cmd_i.emit) begin
      out_q.point_kind   <= cmd_i.emit_kind;
      out_q.count_capped <= capped_q;
      out_q.last         <= 1'b0;
      case (cmd_i.emit_kind)
        sps_pkg::KIND_START: begin
          out_q.point_x <= x1_q;
          out_q.point_y <= y1_q;
        end
        sps_pkg::KIND_END: begin
          out_q.point_x <= x2_q;
          out_q.point_y <= y2_q;
          acc_x_q       <= '0;
          acc_y_q       <= '0;
          idx_q         <= '0;
        end
        default: begin
          out_q.point_x <= sample_coord(x1_q, acc_x_q);
          out_q.point_y <= sample_coord(y1_q, acc_y_q);
          out_q.last    <= last_point;
          // advance to the next sample
          acc_x_q       <= acc_x_q + sps_pkg::ACC_W'(sx_q);
          acc_y_q       <= acc_y_q + sps_pkg::ACC_W'(sy_q);
          idx_q         <= idx_q + sps_pkg::N_W'(1);
        end
      endcase
    end
  end

  assign sts_o.sqrt_last  = bit_q[0];
  assign sts_o.div_done   = div_done;
  assign sts_o.last_point = last_point;
  assign point_o          = out_q;

endmodule

`default_nettype wire

### rtl/sps_ctrl.sv
// Controller: sequences load, square, root, three divides and emission,
// and owns the input ready and output valid. Depends on sps_pkg.
`default_nettype none

module sps_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire sps_pkg::dp_sts_t  sts_i,
  output sps_pkg::dp_cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQ     = 4'd1;
  localparam logic [3:0] S_SUM    = 4'd2;
  localparam logic [3:0] S_SQRT   = 4'd3;
  localparam logic [3:0] S_DIV_N  = 4'd4;
  localparam logic [3:0] S_WAIT_N = 4'd5;
  localparam logic [3:0] S_DIV_X  = 4'd6;
  localparam logic [3:0] S_WAIT_X = 4'd7;
  localparam logic [3:0] S_DIV_Y  = 4'd8;
  localparam logic [3:0] S_WAIT_Y = 4'd9;
  localparam logic [3:0] S_EMIT_S = 4'd10;
  localparam logic [3:0] S_EMIT_E = 4'd11;
  localparam logic [3:0] S_EMIT_P = 4'd12;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.square = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_last) begin
          state_d = S_DIV_N;
        end
      end
      S_DIV_N: begin
        cmd_o.div_sel   = sps_pkg::DIV_ROOT;
        cmd_o.div_start = 1'b1;
        state_d         = S_WAIT_N;
      end
      S_WAIT_N: begin
        cmd_o.div_sel = sps_pkg::DIV_ROOT;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_DIV_X;
        end
      end
      S_DIV_X: begin
        cmd_o.div_sel   = sps_pkg::DIV_DX;
        cmd_o.div_start = 1'b1;
        state_d         = S_WAIT_X;
      end
      S_WAIT_X: begin
        cmd_o.div_sel = sps_pkg::DIV_DX;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        cmd_o.div_sel   = sps_pkg::DIV_DY;
        cmd_o.div_start = 1'b1;
        state_d         = S_WAIT_Y;
      end
      S_WAIT_Y: begin
        cmd_o.div_sel = sps_pkg::DIV_DY;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_EMIT_S;
        end
      end
      S_EMIT_S: begin
        cmd_o.emit_kind = sps_pkg::KIND_START;
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_EMIT_E;
        end
      end
      S_EMIT_E: begin
        cmd_o.emit_kind = sps_pkg::KIND_END;
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_EMIT_P;
        end
      end
      S_EMIT_P: begin
        cmd_o.emit_kind = sps_pkg::KIND_SAMPLE;
        if (out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_point) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the output register until its transfer; reload on emit
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### rtl/segment_point_sampler.sv
// Top level of the segment point sampler: APB step-size register,
// controller and datapath. Depends on sps_pkg, sps_ctrl and sps_dp.
//
// Usage: one segment (start and end point, 20-bit signed each) is taken on
// the input channel when in_valid_i and in_ready_o are both high. For it the
// block returns, one transfer each on the output channel, the start point,
// the end point and then N+1 sampled points, N = floor(|d| / step) + 1
// capped at 61; the last one carries last = 1.
// After the input transfer the block squares and sums, takes the square root
// iteratively, runs three divides on one shared serial divider and loads the
// output register; from then on it returns one result per cycle while the
// receiver does not stall. One segment is in work at a time;
// in_ready_o rises again once its last result sits in the output register.
// A stalled receiver holds the output register and pauses emission.
// Reset clears the controller and sets step_size to 41; step_size 0 is
// used as 1. Write step_size (address 0) only while the block is idle.
`default_nettype none

module segment_point_sampler (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire sps_pkg::seg_in_t             in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output sps_pkg::point_out_t               out_data_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sps_pkg::APB_AW-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [sps_pkg::STEP_W-1:0] step_q;
  sps_pkg::dp_cmd_t           cmd;
  sps_pkg::dp_sts_t           sts;
  logic                       step_wr;

  assign pready  = 1'b1;
  assign step_wr = psel && penable && pwrite && (paddr[2] == sps_pkg::REG_STEP_SIZE);
  assign prdata  = (paddr[2] == sps_pkg::REG_STEP_SIZE) ? 32'(step_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= sps_pkg::STEP_RESET;
    end else if (step_wr) begin
      step_q <= pwdata[sps_pkg::STEP_W-1:0];
    end
  end

  sps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_size_i (step_q),
    .seg_i       (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .point_o     (out_data_o)
  );

endmodule

`default_nettype wire

### rtl/sps_checker.sv
// Port-level checks of the segment point sampler, bound to the top level.
// Depends on sps_pkg and on the top level's port names.
`default_nettype none

module sps_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire sps_pkg::point_out_t          out_data_o,
  input wire logic                         psel,
  input wire logic                         penable,
  input wire logic                         pwrite,
  input wire logic [sps_pkg::APB_AW-1:0]   paddr,
  input wire logic [31:0]                  pwdata,
  input wire logic [31:0]                  prdata,
  input wire logic                         pready
);

  // A waiting result holds its value until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // One segment in work at a time
  a_one_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second segment taken while busy");

  // While a segment is not finished the input stays closed
  a_busy_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("input open in the middle of a segment");

  // Endpoints never close a segment
  a_endpoint_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.point_kind != sps_pkg::KIND_SAMPLE) |-> !out_data_o.last)
    else $error("endpoint marked last");

  // A step-size write reads back
  a_step_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[2] == sps_pkg::REG_STEP_SIZE))
      ##1 (paddr[2] == sps_pkg::REG_STEP_SIZE)
      |-> prdata[sps_pkg::STEP_W-1:0] == $past(pwdata[sps_pkg::STEP_W-1:0]))
    else $error("step_size read back differs");

endmodule

bind segment_point_sampler sps_checker u_sps_checker (.*);

`default_nettype wire

### test/tb_segment_point_sampler.sv
// Self-checking testbench for segment_point_sampler: random segments over
// several step sizes, each point checked against an in-bench prediction.
// Depends on sps_pkg and the segment_point_sampler RTL.

module tb_segment_point_sampler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     IDLE_PCT     = 23;
  localparam int     HOLD_CYCLES  = 800;
  localparam int     DRAIN_CYCLES = 200;
  localparam int     STALL_LIMIT  = 5000;
  localparam longint CRD_HI       = (longint'(1) <<< (sps_pkg::COORD_W - 1)) - 1;
  localparam longint CRD_LO       = -CRD_HI - 1;
  localparam logic [sps_pkg::APB_AW-1:0] STEP_ADDR = {sps_pkg::REG_STEP_SIZE, 2'b00};

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  sps_pkg::seg_in_t           in_data_i   = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  sps_pkg::point_out_t        out_data_o;
  logic                       psel        = 1'b0;
  logic                       penable     = 1'b0;
  logic                       pwrite      = 1'b0;
  logic [sps_pkg::APB_AW-1:0] paddr       = '0;
  logic [31:0]                pwdata      = '0;
  logic [31:0]                prdata;
  logic                       pready;

  sps_pkg::seg_in_t           segments_to_send[$];
  sps_pkg::point_out_t        expected_points[$];
  sps_pkg::point_out_t        want_point;
  logic [sps_pkg::STEP_W-1:0] step_cfg    = sps_pkg::STEP_RESET;
  int                         idle_pct    = IDLE_PCT;
  bit                         hold_go     = 1'b0;
  bit                         hold_seen   = 1'b0;
  int                         hold_left   = 0;
  int                         errors      = 0;
  int                         stall_cnt   = 0;
  bit                         in_fire     = 1'b0;
  bit                         out_fire    = 1'b0;

  segment_point_sampler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic void queue_point(sps_pkg::point_out_t p);
    expected_points = {expected_points, p};
  endfunction

  function automatic void queue_seg(sps_pkg::seg_in_t s);
    segments_to_send = {segments_to_send, s};
  endfunction

  function automatic logic signed [sps_pkg::COORD_W-1:0] clamp_coord(longint v);
    if (v > CRD_HI) v = CRD_HI;
    if (v < CRD_LO) v = CRD_LO;
    return v[sps_pkg::COORD_W-1:0];
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b   = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v  -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Division rounded toward minus infinity, d > 0
  function automatic longint floor_div(longint a, longint d);
    if (a >= 0) return a / d;
    return -((-a + d - 1) / d);
  endfunction

  // Start, end, then n+1 evenly spaced samples for the current step size
  function automatic void predict_points(sps_pkg::seg_in_t seg);
    longint              x1, y1, x2, y2, dx, dy, n, inc_x, inc_y;
    logic                capped;
    sps_pkg::point_out_t pt;
    x1 = seg.start_x;
    y1 = seg.start_y;
    x2 = seg.end_x;
    y2 = seg.end_y;
    dx = x2 - x1;
    dy = y2 - y1;
    n  = longint'(root_floor(dx * dx + dy * dy)) /
         ((step_cfg == 0) ? 1 : longint'(step_cfg)) + 1;
    capped = (n > sps_pkg::MAX_STEPS);
    if (capped) n = sps_pkg::MAX_STEPS;
    inc_x = floor_div(dx * 256, n);
    inc_y = floor_div(dy * 256, n);

    pt.count_capped = capped;
    pt.last         = 1'b0;
    pt.point_x      = seg.start_x;
    pt.point_y      = seg.start_y;
    pt.point_kind   = sps_pkg::KIND_START;
    queue_point(pt);
    pt.point_x      = seg.end_x;
    pt.point_y      = seg.end_y;
    pt.point_kind   = sps_pkg::KIND_END;
    queue_point(pt);
    pt.point_kind   = sps_pkg::KIND_SAMPLE;
    for (longint i = 0; i <= n; i++) begin
      pt.point_x = clamp_coord(x1 + ((i * inc_x) >>> 8));
      pt.point_y = clamp_coord(y1 + ((i * inc_y) >>> 8));
      pt.last    = (i == n);
      queue_point(pt);
    end
  endfunction

  function automatic sps_pkg::seg_in_t make_seg(longint ax, longint ay, longint bx, longint by);
    sps_pkg::seg_in_t s;
    s.start_x = clamp_coord(ax);
    s.start_y = clamp_coord(ay);
    s.end_x   = clamp_coord(bx);
    s.end_y   = clamp_coord(by);
    return s;
  endfunction

  function automatic longint corner_coord();
    case ($urandom_range(3))
      0:       return CRD_LO;
      1:       return CRD_HI;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  function automatic sps_pkg::seg_in_t random_segment();
    sps_pkg::seg_in_t s;
    longint           span;
    int               mode;
    mode      = $urandom_range(9);
    s.start_x = sps_pkg::COORD_W'($urandom);
    s.start_y = sps_pkg::COORD_W'($urandom);
    if (mode < 3) begin
      s.end_x = sps_pkg::COORD_W'($urandom);
      s.end_y = sps_pkg::COORD_W'($urandom);
    end else if (mode == 3) begin
      s = make_seg(corner_coord(), corner_coord(), corner_coord(), corner_coord());
    end else begin
      // log-spread lengths so the step count covers its whole range
      span    = longint'(1) << $urandom_range(0, 20);
      s.end_x = clamp_coord(longint'(s.start_x) +
                            longint'($urandom_range(0, 32'(2 * span))) - span);
      s.end_y = clamp_coord(longint'(s.start_y) +
                            longint'($urandom_range(0, 32'(2 * span))) - span);
    end
    return s;
  endfunction

  // Write step_size, then read it back
  task automatic write_step(input logic [sps_pkg::STEP_W-1:0] value);
    logic [31:0] rd;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = STEP_ADDR;
    pwdata  = 32'(value);
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    step_cfg = value;
    if (rd[sps_pkg::STEP_W-1:0] !== value) begin
      errors++;
      $display("%0t: step_size readback: expected %0d, got %0d", $time, value,
               rd[sps_pkg::STEP_W-1:0]);
    end
  endtask

  task automatic wait_idle(input int settle);
    while (segments_to_send.size() != 0 || in_valid_i || expected_points.size() != 0)
      @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Sample transfers, check points, watch for a hang
  always @(posedge clk_i) begin
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    if (in_fire) predict_points(in_data_i);
    if (out_fire) begin
      if (expected_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected point: x=%0d y=%0d kind=%0d capped=%b last=%b", $time,
                 out_data_o.point_x, out_data_o.point_y, out_data_o.point_kind,
                 out_data_o.count_capped, out_data_o.last);
      end else begin
        want_point = expected_points.pop_front();
        if (out_data_o.point_x !== want_point.point_x ||
            out_data_o.point_y !== want_point.point_y ||
            out_data_o.point_kind !== want_point.point_kind ||
            out_data_o.count_capped !== want_point.count_capped ||
            out_data_o.last !== want_point.last) begin
          errors++;
          $display("%0t: point mismatch: expected x=%0d y=%0d kind=%0d capped=%b last=%b",
                   $time, want_point.point_x, want_point.point_y, want_point.point_kind,
                   want_point.count_capped, want_point.last);
          $display("%0t:                 actual   x=%0d y=%0d kind=%0d capped=%b last=%b",
                   $time, out_data_o.point_x, out_data_o.point_y, out_data_o.point_kind,
                   out_data_o.count_capped, out_data_o.last);
        end
      end
    end
    if (!rst_ni || in_fire || out_fire) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Segment sender: hold the payload until the transfer, then advance
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (segments_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_data_i  <= segments_to_send.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Point receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen   <= hold_go;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin
    logic [sps_pkg::STEP_W-1:0] phase_step[5];
    phase_step = '{16'd7, 16'hFFFF, 16'd1, sps_pkg::STEP_W'($urandom_range(2, 300)),
                   sps_pkg::STEP_W'($urandom_range(301, 65534))};

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset step size: endpoints, extremes, cap boundary, saturation
    queue_seg(make_seg(0, 0, 0, 0));
    queue_seg(make_seg(CRD_HI, CRD_HI, CRD_LO, CRD_LO));
    queue_seg(make_seg(CRD_LO, CRD_LO, CRD_HI, CRD_HI));
    queue_seg(make_seg(CRD_LO, CRD_HI, CRD_HI, CRD_LO));
    queue_seg(make_seg(CRD_HI, CRD_LO, CRD_LO, CRD_HI));
    queue_seg(make_seg(0, 0, 40, 0));
    queue_seg(make_seg(0, 0, 41, 0));
    queue_seg(make_seg(100, -100, 100, -141));
    queue_seg(make_seg(0, 0, 2500, 0));
    queue_seg(make_seg(0, 0, 2501, 0));
    queue_seg(make_seg(-5, 3, 7, -11));
    queue_seg(make_seg(1000, -2000, -1000, 2000));
    queue_seg(make_seg(-349526, 349525, 349525, -349526));
    queue_seg(make_seg(CRD_LO, 0, CRD_LO, 0));
    queue_seg(make_seg(CRD_HI, -1, CRD_HI - 1, CRD_LO));
    wait_idle(4);

    // Zero step acts as one
    write_step('0);
    queue_seg(make_seg(0, 0, 10, -10));
    queue_seg(make_seg(3, 3, 3, 5));
    wait_idle(4);

    write_step('1);
    queue_seg(make_seg(CRD_LO, CRD_LO, CRD_HI, CRD_HI));
    queue_seg(make_seg(CRD_HI, CRD_LO, CRD_LO, CRD_HI));
    wait_idle(4);

    for (int ph = 0; ph < 5; ph++) begin
      write_step(phase_step[ph]);
      idle_pct = (ph == 1) ? 0 : IDLE_PCT;
      repeat (100) queue_seg(random_segment());
      // stall the output long enough for the input side to back up
      if (ph == 3) hold_go = !hold_go;
      wait_idle(4);
    end

    wait_idle(DRAIN_CYCLES);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sps_pkg.sv
rtl/sps_div.sv
rtl/sps_dp.sv
rtl/sps_ctrl.sv
rtl/segment_point_sampler.sv
rtl/sps_checker.sv
test/tb_segment_point_sampler.sv
